// ----- sv/call_graph_profile_recorder_defines.svh -----
// ----------------------------------------------------------------------------
// Call graph profile recorder: assertion macros
// Shared assertion forms for the recorder modules.
// ----------------------------------------------------------------------------
`ifndef CALL_GRAPH_PROFILE_RECORDER_DEFINES_SVH
`define CALL_GRAPH_PROFILE_RECORDER_DEFINES_SVH

// Checked only outside reset.
`define CGPR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define CGPR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/cgpr_pkg.sv -----
// ----------------------------------------------------------------------------
// Call graph profile recorder package
// Sizes, payload types and codes shared by the recorder modules.
// ----------------------------------------------------------------------------
package cgpr_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int NODE_COUNT  = 2048;
  localparam int QUEUE_DEPTH = 2;

  localparam int WORD_W   = 32;
  localparam int CNT_W    = 64;
  localparam int SLOT_W   = $clog2(NODE_COUNT);
  localparam int FREE_W   = $clog2(NODE_COUNT + 1);
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);
  localparam int QPTR_W   = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_STACK_FULL = 2'd2,
    ST_GRAPH_FULL = 2'd3
  } status_t;

  typedef enum logic {
    BK_RUN,
    BK_REFILL
  } back_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] node_data_low;
    logic [WORD_W-1:0] node_data_high;
    logic [CNT_W-1:0]  cycle_count;
    logic [CNT_W-1:0]  event_zero;
    logic [CNT_W-1:0]  event_one;
    logic [CNT_W-1:0]  event_two;
    logic [CNT_W-1:0]  event_three;
    logic [CNT_W-1:0]  event_four;
    logic [CNT_W-1:0]  event_five;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic              was_entry;
    logic [SLOT_W-1:0] node_slot;
    logic [WORD_W-1:0] stored_low_word;
    logic [WORD_W-1:0] stored_high_word;
    logic [CNT_W-1:0]  stored_cycles;
    logic [CNT_W-1:0]  stored_event_zero;
    logic [CNT_W-1:0]  stored_event_one;
    logic [CNT_W-1:0]  stored_event_two;
    logic [CNT_W-1:0]  stored_event_three;
    logic [CNT_W-1:0]  stored_event_four;
    logic [CNT_W-1:0]  stored_event_five;
  } result_t;

  typedef struct packed {
    logic  is_entry;
    item_t ev;
  } queue_entry_t;

  typedef struct packed {
    logic [WORD_W-1:0] high;
    logic [SLOT_W-1:0] slot;
  } frame_t;

endpackage

// ----- sv/cgpr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cgpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/cgpr_front.sv -----
// ----------------------------------------------------------------------------
// Call graph profile recorder: front end
// Accepts events, marks each as entry or exit and queues it for the back end.
// ----------------------------------------------------------------------------
`include "call_graph_profile_recorder_defines.svh"

module cgpr_front import cgpr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  item_t        item,
  output logic         busy,
  output logic         q_valid,
  output queue_entry_t q_head,
  input  logic         q_pop
);

  queue_entry_t       fifo_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  logic [QPTR_W:0]    count_next;
  logic               accept;
  queue_entry_t       entry_in;

  assign busy     = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign accept   = start && !busy;
  assign q_valid  = (count != '0);
  assign q_head   = fifo_mem[rd_ptr];

  always_comb begin
    entry_in.is_entry = (item.node_data_low != '0);
    entry_in.ev       = item;
    count_next = count + {{QPTR_W{1'b0}}, accept} - {{QPTR_W{1'b0}}, q_pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fifo_mem[wr_ptr] <= entry_in;
    end
  end

  `CGPR_ASSERT(a_count_bound, clk, rst, count <= (QPTR_W + 1)'(QUEUE_DEPTH), "queue overfilled")
  `CGPR_ASSERT(a_pop_valid, clk, rst, q_pop |-> q_valid, "pop from empty queue")
  `CGPR_ASSERT(a_fill, clk, rst, (accept && !q_pop) |=> (count == $past(count) + 1'b1), "queue count lost an event")

endmodule

// ----- sv/cgpr_back.sv -----
// ----------------------------------------------------------------------------
// Call graph profile recorder: back end
// Keeps the open-call stack with its top cached and builds the node records.
// ----------------------------------------------------------------------------
`include "call_graph_profile_recorder_defines.svh"

module cgpr_back import cgpr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  queue_entry_t q_head,
  output logic         q_pop,
  output logic         done,
  output result_t      result
);

  back_state_t          state;
  back_state_t          state_next;
  logic [DEPTH_W-1:0]   depth;
  logic [DEPTH_W-1:0]   depth_next;
  logic [DEPTH_W-1:0]   depth_m2;
  logic [FREE_W-1:0]    next_free;
  logic [FREE_W-1:0]    next_free_next;
  frame_t               top;
  frame_t               top_next;
  frame_t               new_frame;
  logic                 done_next;
  result_t              result_next;
  logic                 we;
  logic [STACK_AW-1:0]  waddr;
  logic [STACK_AW-1:0]  raddr;
  logic [$bits(frame_t)-1:0] rdata;

  assign depth_m2 = depth - DEPTH_W'(2);
  assign raddr    = depth_m2[STACK_AW-1:0];
  assign waddr    = depth[STACK_AW-1:0];

  cgpr_ram #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (new_frame),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next     = state;
    depth_next     = depth;
    next_free_next = next_free;
    top_next       = top;
    q_pop          = 1'b0;
    done_next      = 1'b0;
    result_next    = '0;
    we             = 1'b0;
    new_frame.slot = next_free[SLOT_W-1:0];
    new_frame.high = (depth != '0) ? (top.high + WORD_W'(1))
                                   : (q_head.ev.node_data_high | WORD_W'(1));
    unique case (state)
      BK_REFILL: begin
        top_next   = frame_t'(rdata);
        state_next = BK_RUN;
      end
      BK_RUN: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          done_next = 1'b1;
          if (q_head.is_entry) begin
            result_next.was_entry = 1'b1;
            priority if (depth == DEPTH_W'(STACK_DEPTH)) begin
              result_next.status = ST_STACK_FULL;
            end else if (next_free == FREE_W'(NODE_COUNT)) begin
              result_next.status = ST_GRAPH_FULL;
            end else begin
              result_next.status           = ST_OK;
              result_next.node_slot        = new_frame.slot;
              result_next.stored_low_word  = q_head.ev.node_data_low;
              result_next.stored_high_word = new_frame.high;
              we             = 1'b1;
              top_next       = new_frame;
              depth_next     = depth + DEPTH_W'(1);
              next_free_next = next_free + FREE_W'(1);
            end
          end else begin
            if (depth == '0) begin
              result_next.status = ST_EMPTY;
            end else begin
              result_next.status             = ST_OK;
              result_next.node_slot          = top.slot;
              result_next.stored_cycles      = q_head.ev.cycle_count;
              result_next.stored_event_zero  = q_head.ev.event_zero;
              result_next.stored_event_one   = q_head.ev.event_one;
              result_next.stored_event_two   = q_head.ev.event_two;
              result_next.stored_event_three = q_head.ev.event_three;
              result_next.stored_event_four  = q_head.ev.event_four;
              result_next.stored_event_five  = q_head.ev.event_five;
              depth_next = depth - DEPTH_W'(1);
              if (depth != DEPTH_W'(1)) begin
                state_next = BK_REFILL;
              end
            end
          end
        end
      end
      default: begin
        state_next = BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_RUN;
      depth     <= '0;
      next_free <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      depth     <= depth_next;
      next_free <= next_free_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    top    <= top_next;
    result <= result_next;
  end

  `CGPR_ASSERT(a_refill_stall, clk, rst, (state == BK_REFILL) |-> !q_pop, "pop during stack refill")
  `CGPR_ASSERT(a_pop_done, clk, rst, q_pop |=> done, "event popped without a record")
  `CGPR_ASSERT(a_depth_bound, clk, rst, depth <= DEPTH_W'(STACK_DEPTH), "stack depth overflow")

endmodule

// ----- sv/call_graph_profile_recorder.sv -----
// ----------------------------------------------------------------------------
// Call graph profile recorder
// Turns function entry and exit events into node memory write records.
// ----------------------------------------------------------------------------
// An event is taken at a clock edge where start is high and busy is low. Each
// event yields exactly one record on result, marked by done for a single
// cycle; the receiver must take it then. With the queue empty, an event is
// written into the queue and then registered as a record by the back end.
// Events run at one per cycle, except that an exit leaving calls still open
// stalls the back end for a refill, as the new stack top is read back from
// the stack RAM, whose read data is registered. A two-event queue absorbs
// that stall, and busy rises while it is full. No clearing pass follows reset.
module call_graph_profile_recorder import cgpr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result
);

  logic         q_valid;
  logic         q_pop;
  queue_entry_t q_head;

  cgpr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item    (item),
    .busy    (busy),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  cgpr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .done    (done),
    .result  (result)
  );

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Call graph profile recorder testbench
// Sends entry and exit events through the start/busy command handshake and
// predicts every node-memory record from its own copy of the open-call stack
// and the node allocator. Directed events cover the empty-stack exit, the
// root level word and its wrap, and the extremes of every field. Random call
// trees then run, and the end of the run fills the stack and the graph.
// ----------------------------------------------------------------------------
module testbench import cgpr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_EVENTS = 1300;
  localparam int RANDOM_SLOTS  = 1000;

  logic    clk;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  item_t   item  = '0;
  logic    busy;
  logic    done;
  result_t result;

  call_graph_profile_recorder dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  logic [SLOT_W-1:0] call_slot [STACK_DEPTH];
  logic [WORD_W-1:0] call_high [STACK_DEPTH];
  int                call_depth = 0;
  int                slots_used = 0;

  result_t pending_records[$];
  int      mismatches  = 0;
  int      cycles_run  = 0;
  int      sender_gap  = 0;
  int      burst_left  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic result_t record_for_event(input item_t ev);
    result_t           rec;
    logic [WORD_W-1:0] level;
    rec = '0;
    if (ev.node_data_low != '0) begin
      rec.was_entry = 1'b1;
      if (call_depth >= STACK_DEPTH) begin
        rec.status = ST_STACK_FULL;
      end else if (slots_used >= NODE_COUNT) begin
        rec.status = ST_GRAPH_FULL;
      end else begin
        if (call_depth > 0) level = call_high[call_depth-1] + 32'd1;
        else level = ev.node_data_high | 32'h1;
        call_slot[call_depth] = slots_used[SLOT_W-1:0];
        call_high[call_depth] = level;
        call_depth++;
        slots_used++;
        rec.status           = ST_OK;
        rec.node_slot        = call_slot[call_depth-1];
        rec.stored_low_word  = ev.node_data_low;
        rec.stored_high_word = level;
      end
    end else begin
      rec.was_entry = 1'b0;
      if (call_depth == 0) begin
        rec.status = ST_EMPTY;
      end else begin
        call_depth--;
        rec.status             = ST_OK;
        rec.node_slot          = call_slot[call_depth];
        rec.stored_cycles      = ev.cycle_count;
        rec.stored_event_zero  = ev.event_zero;
        rec.stored_event_one   = ev.event_one;
        rec.stored_event_two   = ev.event_two;
        rec.stored_event_three = ev.event_three;
        rec.stored_event_four  = ev.event_four;
        rec.stored_event_five  = ev.event_five;
      end
    end
    return rec;
  endfunction

  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic item_t make_event(input bit is_entry);
    item_t ev;
    ev.node_data_low  = is_entry ? $urandom : 32'd0;
    ev.node_data_high = $urandom;
    ev.cycle_count    = {$urandom, $urandom};
    ev.event_zero     = {$urandom, $urandom};
    ev.event_one      = {$urandom, $urandom};
    ev.event_two      = {$urandom, $urandom};
    ev.event_three    = {$urandom, $urandom};
    ev.event_four     = {$urandom, $urandom};
    ev.event_five     = {$urandom, $urandom};
    if (is_entry && ev.node_data_low == '0) ev.node_data_low = 32'd1;
    return ev;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Each record is on the result port for one cycle only, so every beat
  // marked by done is checked at the edge that ends it.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_records.size() == 0) begin
        report_mismatch("record with no event pending");
      end else begin
        want = pending_records.pop_front();
        check_field("status", result.status, want.status);
        check_field("was_entry", result.was_entry, want.was_entry);
        check_field("node_slot", result.node_slot, want.node_slot);
        check_field("stored_low_word", result.stored_low_word, want.stored_low_word);
        check_field("stored_high_word", result.stored_high_word, want.stored_high_word);
        check_field("stored_cycles", result.stored_cycles, want.stored_cycles);
        check_field("stored_event_zero", result.stored_event_zero, want.stored_event_zero);
        check_field("stored_event_one", result.stored_event_one, want.stored_event_one);
        check_field("stored_event_two", result.stored_event_two, want.stored_event_two);
        check_field("stored_event_three", result.stored_event_three,
                    want.stored_event_three);
        check_field("stored_event_four", result.stored_event_four, want.stored_event_four);
        check_field("stored_event_five", result.stored_event_five, want.stored_event_five);
      end
    end
  end

  // Start stays high from one beat to the next when no gap is drawn.
  task automatic send_event(input item_t ev);
    repeat (sender_gap) @(posedge clk);
    item  <= ev;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_records.push_back(record_for_event(ev));
    sender_gap = next_gap();
    if (sender_gap != 0) start <= 1'b0;
  endtask

  task automatic drain_phase();
    if (sender_gap == 0) start <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_entry(input logic [WORD_W-1:0] low, input logic [WORD_W-1:0] high);
    item_t ev;
    ev = make_event(1'b1);
    ev.node_data_low  = low;
    ev.node_data_high = high;
    send_event(ev);
  endtask

  task automatic send_exit_counts(input logic [CNT_W-1:0] value);
    item_t ev;
    ev = make_event(1'b0);
    ev.cycle_count = value;
    ev.event_zero  = value;
    ev.event_one   = value;
    ev.event_two   = value;
    ev.event_three = value;
    ev.event_four  = value;
    ev.event_five  = value;
    send_event(ev);
  endtask

  task automatic close_open_calls();
    while (call_depth > 0) send_event(make_event(1'b0));
  endtask

  task automatic test_empty_stack_exit();
    send_exit_counts('1);
    send_exit_counts('0);
    drain_phase();
  endtask

  task automatic test_levels_and_extremes();
    send_entry(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_entry(32'h0000_0001, 32'h0000_0000);
    send_entry(32'h8000_0000, 32'hFFFF_FFFF);
    send_exit_counts('1);
    send_exit_counts('0);
    send_event(make_event(1'b0));
    send_exit_counts('1);
    send_entry(32'h5555_5555, 32'h0000_0000);
    send_entry(32'hAAAA_AAAA, 32'h5555_5554);
    send_event(make_event(1'b0));
    send_event(make_event(1'b0));
    send_entry(32'h0000_0002, 32'hFFFF_FFFF);
    send_event(make_event(1'b0));
    send_entry(32'h1234_5678, 32'hAAAA_AAAA);
    send_event(make_event(1'b0));
    send_event(make_event(1'b0));
    drain_phase();
  endtask

  task automatic test_random_call_trees();
    int  depth_cap;
    bit  take_entry;
    depth_cap = 8;
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (call_depth == 0) begin
        depth_cap  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 24);
        take_entry = ($urandom_range(0, 9) != 0);
      end else begin
        take_entry = (call_depth < depth_cap) && ($urandom_range(0, 1) == 1);
      end
      if (slots_used >= RANDOM_SLOTS) take_entry = 1'b0;
      send_event(make_event(take_entry));
    end
    close_open_calls();
    drain_phase();
  endtask

  task automatic test_stack_and_graph_full();
    while (slots_used < NODE_COUNT - STACK_DEPTH) begin
      send_event(make_event(1'b1));
      send_event(make_event(1'b0));
    end
    for (int n = 0; n < STACK_DEPTH; n++) send_event(make_event(1'b1));
    send_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(make_event(1'b1));
    send_exit_counts('1);
    send_entry(32'hFFFF_FFFF, 32'h0000_0000);
    send_event(make_event(1'b1));
    close_open_calls();
    send_event(make_event(1'b0));
    send_event(make_event(1'b1));
    for (int n = 0; n < 40; n++) send_event(make_event(1'($urandom_range(0, 1))));
    drain_phase();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_stack_exit();
    test_levels_and_extremes();
    test_random_call_trees();
    test_stack_and_graph_full();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- call_graph_profile_recorder.f -----
+incdir+sv
sv/cgpr_pkg.sv
sv/cgpr_ram.sv
sv/cgpr_front.sv
sv/cgpr_back.sv
sv/call_graph_profile_recorder.sv
test/testbench.sv
